/* hw/rtl/prts_pkg.sv */
// Shared types, codes and field widths of the periodic task release scheduler.
package prts_pkg;

  // Field widths fixed by the item layout.
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned PER_W  = 32;
  localparam int unsigned ID_W   = 5;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned TICK_W = 10;
  localparam int unsigned TIME_W = 64;

  localparam logic [TICK_W-1:0] TICK_MS_RESET = 10'd10;

  // Input action codes.
  typedef enum logic [ACT_W-1:0] {
    ACT_REGISTER = 3'd0,
    ACT_KILL     = 3'd1,
    ACT_ACTIVATE = 3'd2,
    ACT_TICK     = 3'd3,
    ACT_DISPATCH = 3'd4,
    ACT_COMPLETE = 3'd5
  } act_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BUSY  = 2'd3
  } status_e;

  // Scheduler mode codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE    = 2'd0,
    MODE_EXEC    = 2'd1,
    MODE_OVERRUN = 2'd2
  } mode_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_REG_DIV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PRE_MIN,
    S_MIN_RD,
    S_MIN_CHK,
    S_CMP_CALC,
    S_CMP_CHK,
    S_CMP_DIV,
    S_OUT
  } ctrl_state_e;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_FAIL,
    OP_BUSY,
    OP_EMPTY,
    OP_KILL,
    OP_ACTIVATE,
    OP_TICK,
    OP_DIV_REG,
    OP_REG_COMMIT,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_START,
    OP_CLOSE,
    OP_MIN_INIT,
    OP_MIN_RD,
    OP_MIN_UPD,
    OP_TARGET,
    OP_CMP_RD,
    OP_CMP_CALC,
    OP_DIV_CMP,
    OP_CMP_FIN,
    OP_CMP_FIX,
    OP_OUT
  } dp_op_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             reg_pre_ok;
    logic             id_ok;
    logic             id_live;
    logic             running;
    logic             drain_open;
    logic             scan_end;
    logic             scan_hit;
    logic             scan_second;
    logic             proc_lt_now;
    logic             div_done;
    logic             rem_zero;
    logic             rel_le_now;
    logic             out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/prts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module prts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/prts_div.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module prts_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [prts_pkg::TIME_W-1:0]   dividend_i,
  input  logic [prts_pkg::PER_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [prts_pkg::PER_W-1:0]    quot_o,
  output logic [prts_pkg::PER_W-1:0]    rem_o
);

  localparam int unsigned STEPS = prts_pkg::TIME_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned DW    = prts_pkg::PER_W;

  logic                 busy_q, done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [STEPS-1:0]     quo_q;
  logic [DW-1:0]        rem_q, div_q;
  logic [DW:0]          trial, diff;
  logic                 ge;

  // Shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[STEPS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = ~diff[DW];

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Iteration registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= '0;
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      quo_q <= {quo_q[STEPS-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[DW-1:0];
  assign rem_o  = rem_q;

endmodule

/* hw/rtl/prts_ctrl.sv */
// Controller state machine that sequences each action through the datapath.
module prts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  prts_pkg::dp_stat_t  stat_i,
  output prts_pkg::dp_op_e    op_o
);

  prts_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_d         = state_q;
    op_o            = prts_pkg::OP_NONE;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      prts_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_o    = prts_pkg::OP_LATCH;
          state_d = prts_pkg::S_DECODE;
        end
      end
      prts_pkg::S_DECODE: begin
        state_d = prts_pkg::S_OUT;
        unique case (stat_i.act)
          prts_pkg::ACT_REGISTER: begin
            if (stat_i.reg_pre_ok) begin
              op_o    = prts_pkg::OP_DIV_REG;
              state_d = prts_pkg::S_REG_DIV;
            end else begin
              op_o = prts_pkg::OP_FAIL;
            end
          end
          prts_pkg::ACT_KILL: begin
            op_o = stat_i.id_ok ? prts_pkg::OP_KILL : prts_pkg::OP_FAIL;
          end
          prts_pkg::ACT_ACTIVATE: begin
            op_o = (stat_i.id_ok && stat_i.id_live) ? prts_pkg::OP_ACTIVATE
                                                    : prts_pkg::OP_FAIL;
          end
          prts_pkg::ACT_TICK: begin
            op_o = prts_pkg::OP_TICK;
          end
          prts_pkg::ACT_DISPATCH: begin
            if (stat_i.running) begin
              op_o = prts_pkg::OP_BUSY;
            end else if (stat_i.drain_open) begin
              op_o    = prts_pkg::OP_SCAN_INIT;
              state_d = prts_pkg::S_SCAN_RD;
            end else begin
              state_d = prts_pkg::S_PRE_MIN;
            end
          end
          prts_pkg::ACT_COMPLETE: begin
            if (stat_i.running) begin
              op_o    = prts_pkg::OP_CMP_RD;
              state_d = prts_pkg::S_CMP_CALC;
            end else begin
              op_o = prts_pkg::OP_FAIL;
            end
          end
          default: begin
            op_o = prts_pkg::OP_FAIL;
          end
        endcase
      end
      prts_pkg::S_REG_DIV: begin
        if (stat_i.div_done) begin
          op_o    = stat_i.rem_zero ? prts_pkg::OP_REG_COMMIT : prts_pkg::OP_FAIL;
          state_d = prts_pkg::S_OUT;
        end
      end
      prts_pkg::S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          // No ready task at this processed tick: the drain closes.
          op_o    = prts_pkg::OP_CLOSE;
          state_d = stat_i.scan_second ? prts_pkg::S_OUT : prts_pkg::S_PRE_MIN;
        end else begin
          op_o    = prts_pkg::OP_SCAN_RD;
          state_d = prts_pkg::S_SCAN_CHK;
        end
      end
      prts_pkg::S_SCAN_CHK: begin
        if (stat_i.scan_hit) begin
          op_o    = prts_pkg::OP_START;
          state_d = prts_pkg::S_OUT;
        end else begin
          op_o    = prts_pkg::OP_SCAN_NEXT;
          state_d = prts_pkg::S_SCAN_RD;
        end
      end
      prts_pkg::S_PRE_MIN: begin
        if (stat_i.proc_lt_now) begin
          op_o    = prts_pkg::OP_MIN_INIT;
          state_d = prts_pkg::S_MIN_RD;
        end else begin
          op_o    = prts_pkg::OP_EMPTY;
          state_d = prts_pkg::S_OUT;
        end
      end
      prts_pkg::S_MIN_RD: begin
        if (stat_i.scan_end) begin
          op_o    = prts_pkg::OP_TARGET;
          state_d = prts_pkg::S_SCAN_RD;
        end else begin
          op_o    = prts_pkg::OP_MIN_RD;
          state_d = prts_pkg::S_MIN_CHK;
        end
      end
      prts_pkg::S_MIN_CHK: begin
        op_o    = prts_pkg::OP_MIN_UPD;
        state_d = prts_pkg::S_MIN_RD;
      end
      prts_pkg::S_CMP_CALC: begin
        op_o    = prts_pkg::OP_CMP_CALC;
        state_d = prts_pkg::S_CMP_CHK;
      end
      prts_pkg::S_CMP_CHK: begin
        if (stat_i.rel_le_now) begin
          op_o    = prts_pkg::OP_DIV_CMP;
          state_d = prts_pkg::S_CMP_DIV;
        end else begin
          op_o    = prts_pkg::OP_CMP_FIN;
          state_d = prts_pkg::S_OUT;
        end
      end
      prts_pkg::S_CMP_DIV: begin
        if (stat_i.div_done) begin
          op_o    = prts_pkg::OP_CMP_FIX;
          state_d = prts_pkg::S_OUT;
        end
      end
      prts_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          op_o    = prts_pkg::OP_OUT;
          state_d = prts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/prts_datapath.sv */
// Scheduler datapath: time counters, task tables, divider and result registers.
module prts_datapath #(
  parameter int unsigned MAX_TASKS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prts_pkg::dp_op_e              op_i,
  output prts_pkg::dp_stat_t            stat_o,
  input  logic [39:0]                   s_axis_tdata_i,
  input  logic                          cfg_valid_i,
  input  logic [prts_pkg::TICK_W-1:0]   cfg_data_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [15:0]                   m_axis_tdata_o
);

  localparam int unsigned IW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW  = $clog2(MAX_TASKS + 1);
  localparam int unsigned XW  = (CW > prts_pkg::ID_W) ? CW : prts_pkg::ID_W;
  localparam int unsigned TW  = prts_pkg::TIME_W;
  localparam int unsigned PW  = prts_pkg::PER_W;

  // Latched input item.
  logic [prts_pkg::ACT_W-1:0] act_q;
  logic [PW-1:0]              per_ms_q;
  logic [prts_pkg::ID_W-1:0]  id_q;

  // Scheduler state.
  logic [prts_pkg::TICK_W-1:0] tick_q;
  logic [TW-1:0]               now_q, proc_q, start_q;
  logic                        drain_q, run_q;
  logic [CW-1:0]               count_q;
  logic [IW-1:0]               rr_q, run_idx_q;
  logic [MAX_TASKS-1:0]        live_q;
  prts_pkg::mode_e             mode_q;

  // Scan and completion work registers.
  logic [CW-1:0]  i_q;
  logic [IW-1:0]  idx_q;
  logic           second_q, any_q;
  logic [TW-1:0]  min_q, rel_q;
  logic [PW-1:0]  per_q;

  // Result staging and output register.
  prts_pkg::status_e          res_status_q;
  logic [prts_pkg::ID_W-1:0]  res_id_q;
  logic                       res_ovr_q;
  logic                       out_valid_q;
  prts_pkg::status_e          out_status_q;
  logic [prts_pkg::ID_W-1:0]  out_id_q;
  logic                       out_ovr_q;
  prts_pkg::mode_e            out_mode_q;

  // Table and divider signals.
  logic            rel_we, per_we;
  logic [IW-1:0]   rel_waddr, rel_raddr, id_idx, i_idx;
  logic [TW-1:0]   rel_wdata, rel_rdata;
  logic [PW-1:0]   per_rdata, per_eff;
  logic            div_start, div_done;
  logic [TW-1:0]   div_dividend;
  logic [PW-1:0]   div_divisor, div_quot, div_rem;
  logic [XW-1:0]   id_x;
  logic [IW-1:0]   idx_inc;
  logic [TW-1:0]   tgt, proc_inc;

  assign id_x   = XW'(id_q);
  assign id_idx = id_x[IW-1:0];
  assign i_idx  = i_q[IW-1:0];

  // Round-robin wrap of the scan index.
  assign idx_inc = ((CW'(idx_q) + CW'(1)) == count_q) ? '0 : IW'(CW'(idx_q) + CW'(1));

  // Next processed tick after the minimum-release search.
  assign proc_inc = proc_q + TW'(1);
  always_comb begin
    if (!any_q) begin
      tgt = now_q;
    end else if (min_q > proc_inc) begin
      tgt = (min_q < now_q) ? min_q : now_q;
    end else begin
      tgt = proc_inc;
    end
  end

  assign per_eff = (per_rdata == '0) ? PW'(1) : per_rdata;

  // Table ports and divider operands.
  always_comb begin
    rel_we    = 1'b0;
    per_we    = 1'b0;
    rel_waddr = run_idx_q;
    rel_wdata = now_q;
    unique case (op_i)
      prts_pkg::OP_REG_COMMIT: begin
        rel_we    = 1'b1;
        per_we    = 1'b1;
        rel_waddr = count_q[IW-1:0];
      end
      prts_pkg::OP_ACTIVATE: begin
        rel_we    = 1'b1;
        rel_waddr = id_idx;
      end
      prts_pkg::OP_CMP_FIN: begin
        rel_we    = 1'b1;
        rel_wdata = rel_q;
      end
      prts_pkg::OP_CMP_FIX: begin
        rel_we    = 1'b1;
        rel_wdata = now_q - TW'(div_rem) + TW'(per_q);
      end
      default: begin
      end
    endcase
  end

  assign rel_raddr = (op_i == prts_pkg::OP_CMP_RD) ? run_idx_q :
                     (op_i == prts_pkg::OP_MIN_RD) ? i_idx : idx_q;

  assign div_start    = (op_i == prts_pkg::OP_DIV_REG) || (op_i == prts_pkg::OP_DIV_CMP);
  assign div_dividend = (op_i == prts_pkg::OP_DIV_REG) ? TW'(per_ms_q) : (now_q - rel_q);
  assign div_divisor  = (op_i == prts_pkg::OP_DIV_REG) ? PW'(tick_q) : per_q;

  prts_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_rel_ram (
    .clk_i   (clk_i),
    .we_i    (rel_we),
    .waddr_i (rel_waddr),
    .wdata_i (rel_wdata),
    .raddr_i (rel_raddr),
    .rdata_o (rel_rdata)
  );

  prts_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_per_ram (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (div_quot),
    .raddr_i (run_idx_q),
    .rdata_o (per_rdata)
  );

  prts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Scheduler state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= prts_pkg::TICK_MS_RESET;
      now_q       <= '0;
      proc_q      <= '0;
      start_q     <= '0;
      drain_q     <= 1'b0;
      run_q       <= 1'b0;
      count_q     <= '0;
      rr_q        <= '0;
      run_idx_q   <= '0;
      live_q      <= '0;
      mode_q      <= prts_pkg::MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tick_q <= cfg_data_i;
      end
      if (op_i == prts_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (op_i)
        prts_pkg::OP_REG_COMMIT: begin
          live_q[count_q[IW-1:0]] <= 1'b1;
          count_q                 <= count_q + CW'(1);
          if (count_q == '0) begin
            rr_q <= '0;
          end
        end
        prts_pkg::OP_KILL: begin
          live_q[id_idx] <= 1'b0;
        end
        prts_pkg::OP_TICK: begin
          now_q <= now_q + TW'(1);
        end
        prts_pkg::OP_START: begin
          rr_q      <= idx_inc;
          run_q     <= 1'b1;
          run_idx_q <= idx_q;
          start_q   <= now_q;
          mode_q    <= prts_pkg::MODE_EXEC;
        end
        prts_pkg::OP_CLOSE: begin
          drain_q <= 1'b0;
          mode_q  <= prts_pkg::MODE_IDLE;
        end
        prts_pkg::OP_TARGET: begin
          proc_q  <= tgt;
          drain_q <= 1'b1;
        end
        prts_pkg::OP_CMP_CALC: begin
          mode_q <= ((now_q - start_q) > TW'(per_rdata)) ? prts_pkg::MODE_OVERRUN
                                                         : prts_pkg::MODE_IDLE;
        end
        prts_pkg::OP_CMP_FIN, prts_pkg::OP_CMP_FIX: begin
          run_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Work registers and result staging.
  always_ff @(posedge clk_i) begin
    if (op_i == prts_pkg::OP_OUT) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_ovr_q    <= res_ovr_q;
      out_mode_q   <= mode_q;
    end
    unique case (op_i)
      prts_pkg::OP_LATCH: begin
        act_q    <= s_axis_tdata_i[2:0];
        per_ms_q <= s_axis_tdata_i[34:3];
        id_q     <= s_axis_tdata_i[39:35];
      end
      prts_pkg::OP_FAIL: begin
        res_status_q <= prts_pkg::ST_FAIL;
        res_id_q     <= '0;
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_BUSY: begin
        res_status_q <= prts_pkg::ST_BUSY;
        res_id_q     <= prts_pkg::ID_W'(run_idx_q);
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_EMPTY, prts_pkg::OP_CLOSE: begin
        res_status_q <= prts_pkg::ST_EMPTY;
        res_id_q     <= '0;
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_KILL, prts_pkg::OP_ACTIVATE, prts_pkg::OP_TICK: begin
        res_status_q <= prts_pkg::ST_OK;
        res_id_q     <= '0;
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_REG_COMMIT: begin
        res_status_q <= prts_pkg::ST_OK;
        res_id_q     <= prts_pkg::ID_W'(count_q);
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_SCAN_INIT: begin
        i_q      <= '0;
        idx_q    <= rr_q;
        second_q <= 1'b0;
      end
      prts_pkg::OP_SCAN_NEXT: begin
        i_q   <= i_q + CW'(1);
        idx_q <= idx_inc;
      end
      prts_pkg::OP_START: begin
        res_status_q <= prts_pkg::ST_OK;
        res_id_q     <= prts_pkg::ID_W'(idx_q);
        res_ovr_q    <= 1'b0;
      end
      prts_pkg::OP_MIN_INIT: begin
        i_q   <= '0;
        any_q <= 1'b0;
      end
      prts_pkg::OP_MIN_UPD: begin
        i_q <= i_q + CW'(1);
        if (live_q[i_idx] && (!any_q || rel_rdata < min_q)) begin
          min_q <= rel_rdata;
          any_q <= 1'b1;
        end
      end
      prts_pkg::OP_TARGET: begin
        i_q      <= '0;
        idx_q    <= rr_q;
        second_q <= 1'b1;
      end
      prts_pkg::OP_CMP_CALC: begin
        per_q     <= per_eff;
        rel_q     <= rel_rdata + TW'(per_eff);
        res_ovr_q <= ((now_q - start_q) > TW'(per_rdata));
      end
      prts_pkg::OP_CMP_FIN, prts_pkg::OP_CMP_FIX: begin
        res_status_q <= prts_pkg::ST_OK;
        res_id_q     <= prts_pkg::ID_W'(run_idx_q);
      end
      default: begin
      end
    endcase
  end

  // Status to the controller.
  assign stat_o.act         = act_q;
  assign stat_o.reg_pre_ok  = (count_q < CW'(MAX_TASKS)) && (tick_q != '0) && (per_ms_q != '0);
  assign stat_o.id_ok       = id_x < XW'(count_q);
  assign stat_o.id_live     = live_q[id_idx];
  assign stat_o.running     = run_q;
  assign stat_o.drain_open  = drain_q;
  assign stat_o.scan_end    = (i_q == count_q);
  assign stat_o.scan_hit    = live_q[idx_q] && (proc_q >= rel_rdata);
  assign stat_o.scan_second = second_q;
  assign stat_o.proc_lt_now = proc_q < now_q;
  assign stat_o.div_done    = div_done;
  assign stat_o.rem_zero    = (div_rem == '0);
  assign stat_o.rel_le_now  = rel_q <= now_q;
  assign stat_o.out_free    = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_mode_q, out_ovr_q, out_id_q, out_status_q};

endmodule

/* hw/rtl/periodic_task_release_scheduler.sv */
// Top level of the periodic task release scheduler.
//
//  Channel   Direction  Beat fields (lowest bit up)
//  s_axis    in         action[2:0], period_len[34:3], task_id[39:35]
//  m_axis    out        status[1:0], result_id[6:2], overrun[7], sched_mode[9:8]
//  cfg       in         tick_ms[9:0]
//
// Kill, activate, tick and actions that fail at decode go from decode straight to
// the output stage; register waits on the bit-serial divider. Complete waits on the
// divider only when it has to move a lagging release past the current tick. Dispatch
// reads one release table entry per read and check state pair in each scan pass
// and in the minimum search, with at most two passes and one search.
// Reset is asynchronous and clears all control state. The block takes one beat
// at a time; a finished result waits in the output register while the next beat
// is accepted.
module periodic_task_release_scheduler #(
  parameter int unsigned MAX_TASKS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // action[2:0], period_len[34:3], task_id[39:35]
  input  logic [39:0]                  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status[1:0], result_id[6:2], overrun[7], sched_mode[9:8]
  output logic [15:0]                  m_axis_tdata_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [prts_pkg::TICK_W-1:0]  cfg_data_i
);

  prts_pkg::dp_op_e   op;
  prts_pkg::dp_stat_t stat;

  // The tick length register takes a write at any time.
  assign cfg_ready_o = 1'b1;

  prts_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .stat_i          (stat),
    .op_o            (op)
  );

  prts_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .stat_o          (stat),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // A busy result only occurs while a task is executing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1:0] == prts_pkg::ST_BUSY)
      |-> (m_axis_tdata_o[9:8] == prts_pkg::MODE_EXEC))
    else $error("busy result outside executing mode");

  // A flagged overrun leaves the scheduler in overrun mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[7])
      |-> (m_axis_tdata_o[9:8] == prts_pkg::MODE_OVERRUN))
    else $error("overrun flagged without overrun mode");

  // After an accepted beat the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted twice in a row");

endmodule
